// File: rtl/set_median_select_macros.svh
// ============================================================================
// Set median select assertion macros
// Assertion helpers clocked on clk and disabled while rst_n is low.
// ============================================================================
`ifndef SET_MEDIAN_SELECT_MACROS_SVH
`define SET_MEDIAN_SELECT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define SMS_ASSERT_IMP(lbl, cond, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("set_median_select: check failed");
// Next-cycle implication.
`define SMS_ASSERT_NXT(lbl, cond, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("set_median_select: check failed");
`else
`define SMS_ASSERT_IMP(lbl, cond, expr)
`define SMS_ASSERT_NXT(lbl, cond, expr)
`endif
`endif

// File: rtl/smsel_pkg.sv
// ============================================================================
// Set median select package
// Shared constants and the structs passed between front, queue and executor.
// ============================================================================
package smsel_pkg;

    localparam int MAX_SET    = 64;
    localparam int ADDR_W     = (MAX_SET > 1) ? $clog2(MAX_SET) : 1;
    localparam int CNT_W      = $clog2(MAX_SET + 1);
    localparam int BANK_DEPTH = 1 << ADDR_W;
    localparam int SAMPLE_W   = 32;
    localparam int MEDIAN_W   = 33;
    localparam int SIZE_W     = 7;
    localparam int JOB_DEPTH  = 2;
    localparam int JOB_PTR_W  = $clog2(JOB_DEPTH);

    localparam logic [SAMPLE_W-1:0] SIGN_FLIP = {1'b1, {(SAMPLE_W-1){1'b0}}};

    // One closed set waiting for selection.
    typedef struct packed {
        logic             bank;
        logic [CNT_W-1:0] size;
        logic             ovf;
    } job_t;

    // Sample store write port.
    typedef struct packed {
        logic                en;
        logic [ADDR_W:0]     addr;
        logic [SAMPLE_W-1:0] data;
    } store_wr_t;

    // Bank handed back once its result has been delivered.
    typedef struct packed {
        logic valid;
        logic bank;
    } bank_rel_t;

endpackage

// File: rtl/smsel_queue.sv
// ============================================================================
// Set median select job queue
// Small FIFO of closed sets between the loader and the selection engine.
// ============================================================================
module smsel_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  smsel_pkg::job_t    push_job,
    input  logic               pop,
    output smsel_pkg::job_t    head_job,
    output logic               full,
    output logic               empty
);
    import smsel_pkg::*;

    job_t                 entry_reg [JOB_DEPTH];
    logic [JOB_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [JOB_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [JOB_PTR_W:0]   fill_reg, fill_next;

    assign full     = (fill_reg == (JOB_PTR_W+1)'(JOB_DEPTH));
    assign empty    = (fill_reg == '0);
    assign head_job = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// File: rtl/smsel_front.sv
// ============================================================================
// Set median select loader
// Accepts samples, writes them into the current bank and closes sets.
// ============================================================================
module smsel_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [31:0]                 sample,
    input  logic                        last,
    input  logic                        q_full,
    output logic                        q_push,
    output smsel_pkg::job_t             q_job,
    output smsel_pkg::store_wr_t        store_wr,
    input  smsel_pkg::bank_rel_t        bank_rel
);
    import smsel_pkg::*;

    logic             bank_reg, bank_next;
    logic [1:0]       busy_reg, busy_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic             accept;
    logic             room;
    logic [CNT_W-1:0] count_new;
    logic             ovf_new;

    assign in_ready  = !busy_reg[bank_reg] && !q_full;
    assign accept    = in_valid && in_ready;
    assign room      = (count_reg < CNT_W'(MAX_SET));
    assign count_new = room ? count_reg + 1'b1 : count_reg;
    assign ovf_new   = ovf_reg || !room;

    assign store_wr.en   = accept && room;
    assign store_wr.addr = {bank_reg, count_reg[ADDR_W-1:0]};
    assign store_wr.data = sample;

    assign q_push     = accept && last;
    assign q_job.bank = bank_reg;
    assign q_job.size = count_new;
    assign q_job.ovf  = ovf_new;

    always_comb
    begin
        bank_next  = bank_reg;
        busy_next  = busy_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (bank_rel.valid)
        begin
            busy_next[bank_rel.bank] = 1'b0;
        end
        if (accept)
        begin
            count_next = count_new;
            ovf_next   = ovf_new;
            if (last)
            begin
                // The closed bank stays owned by the selection engine until released.
                busy_next[bank_reg] = 1'b1;
                bank_next  = !bank_reg;
                count_next = '0;
                ovf_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg  <= 1'b0;
            busy_reg  <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            bank_reg  <= bank_next;
            busy_reg  <= busy_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

// File: rtl/smsel_exec.sv
// ============================================================================
// Set median select engine
// Holds the two-bank sample store and finds both middle ranks by radix select.
// ============================================================================
module smsel_exec (
    input  logic                        clk,
    input  logic                        rst_n,
    input  smsel_pkg::store_wr_t        store_wr,
    input  logic                        q_empty,
    input  smsel_pkg::job_t             q_head,
    output logic                        q_pop,
    output smsel_pkg::bank_rel_t        bank_rel,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [32:0]          median_doubled,
    output logic [6:0]                  set_size,
    output logic                        overflowed
);
    import smsel_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DECIDE = 4'b0100,
        ST_OUT    = 4'b1000
    } state_t;

    logic [SAMPLE_W-1:0] store_mem [2*BANK_DEPTH];
    logic [SAMPLE_W-1:0] rdata_reg;

    state_t                state_reg, state_next;
    logic                  bank_reg, bank_next;
    logic [CNT_W-1:0]      size_reg, size_next;
    logic                  ovf_reg, ovf_next;
    logic [ADDR_W-1:0]     idx_reg, idx_next;
    logic                  issued_reg, issued_next;
    logic                  rd_vld_reg, rd_vld_next;
    logic                  rd_en;
    logic [SAMPLE_W-1:0]   pa_reg, pa_next, pb_reg, pb_next;
    logic [SAMPLE_W-1:0]   mask_reg, mask_next, bitsel_reg, bitsel_next;
    logic [CNT_W-1:0]      ka_reg, ka_next, kb_reg, kb_next;
    logic [CNT_W-1:0]      ca_reg, ca_next, cb_reg, cb_next;
    logic signed [MEDIAN_W-1:0] med_reg, med_next;
    logic [SAMPLE_W-1:0]   key;
    logic                  hit_a, hit_b;
    logic [SAMPLE_W-1:0]   sa, sb;

    // Keys are offset binary so unsigned compares follow signed order.
    assign key   = rdata_reg ^ SIGN_FLIP;
    assign hit_a = (((key ^ pa_reg) & mask_reg) == '0) && ((key & bitsel_reg) == '0);
    assign hit_b = (((key ^ pb_reg) & mask_reg) == '0) && ((key & bitsel_reg) == '0);

    always_ff @(posedge clk)
    begin
        if (store_wr.en)
        begin
            store_mem[store_wr.addr] <= store_wr.data;
        end
        if (rd_en)
        begin
            rdata_reg <= store_mem[{bank_reg, idx_reg}];
        end
    end

    assign q_pop          = (state_reg == ST_IDLE) && !q_empty;
    assign out_valid      = (state_reg == ST_OUT);
    assign bank_rel.valid = out_valid && out_ready;
    assign bank_rel.bank  = bank_reg;
    assign median_doubled = med_reg;
    assign set_size       = SIZE_W'(size_reg);
    assign overflowed     = ovf_reg;

    always_comb
    begin
        state_next  = state_reg;
        bank_next   = bank_reg;
        size_next   = size_reg;
        ovf_next    = ovf_reg;
        idx_next    = idx_reg;
        issued_next = issued_reg;
        rd_en       = 1'b0;
        pa_next     = pa_reg;
        pb_next     = pb_reg;
        mask_next   = mask_reg;
        bitsel_next = bitsel_reg;
        ka_next     = ka_reg;
        kb_next     = kb_reg;
        ca_next     = ca_reg;
        cb_next     = cb_reg;
        med_next    = med_reg;
        sa          = '0;
        sb          = '0;

        if (rd_vld_reg)
        begin
            ca_next = ca_reg + CNT_W'(hit_a);
            cb_next = cb_reg + CNT_W'(hit_b);
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    bank_next   = q_head.bank;
                    size_next   = q_head.size;
                    ovf_next    = q_head.ovf;
                    ka_next     = (q_head.size - 1'b1) >> 1;
                    kb_next     = q_head.size >> 1;
                    pa_next     = '0;
                    pb_next     = '0;
                    mask_next   = '0;
                    bitsel_next = SIGN_FLIP;
                    ca_next     = '0;
                    cb_next     = '0;
                    idx_next    = '0;
                    issued_next = 1'b0;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!issued_reg)
                begin
                    rd_en = 1'b1;
                    if (CNT_W'(idx_reg) == size_reg - 1'b1)
                    begin
                        issued_next = 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else if (!rd_vld_reg)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                // No more matches with a zero bit than the wanted zero-based rank: the bit is one.
                if (ka_reg >= ca_reg)
                begin
                    pa_next = pa_reg | bitsel_reg;
                    ka_next = ka_reg - ca_reg;
                end
                if (kb_reg >= cb_reg)
                begin
                    pb_next = pb_reg | bitsel_reg;
                    kb_next = kb_reg - cb_reg;
                end
                mask_next   = mask_reg | bitsel_reg;
                bitsel_next = bitsel_reg >> 1;
                ca_next     = '0;
                cb_next     = '0;
                idx_next    = '0;
                issued_next = 1'b0;
                if (bitsel_reg[0])
                begin
                    sa         = pa_next ^ SIGN_FLIP;
                    sb         = pb_next ^ SIGN_FLIP;
                    med_next   = $signed({sa[SAMPLE_W-1], sa}) + $signed({sb[SAMPLE_W-1], sb});
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        rd_vld_next = rd_en;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            issued_reg <= 1'b0;
            rd_vld_reg <= 1'b0;
            ca_reg     <= '0;
            cb_reg     <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            issued_reg <= issued_next;
            rd_vld_reg <= rd_vld_next;
            ca_reg     <= ca_next;
            cb_reg     <= cb_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bank_reg   <= bank_next;
        size_reg   <= size_next;
        ovf_reg    <= ovf_next;
        idx_reg    <= idx_next;
        pa_reg     <= pa_next;
        pb_reg     <= pb_next;
        mask_reg   <= mask_next;
        bitsel_reg <= bitsel_next;
        ka_reg     <= ka_next;
        kb_reg     <= kb_next;
        med_reg    <= med_next;
    end

endmodule

// File: rtl/set_median_select.sv
// ============================================================================
// Set median select
// Collects a set of signed Q16.16 samples and returns twice their median.
// ============================================================================
// Usage: samples enter on in_valid/in_ready with sample and last; the
// transaction with last set closes the set. One result per set leaves on
// out_valid/out_ready: median_doubled (sum of the two middle elements, or
// twice the middle one), set_size and overflowed. Samples past 64 per set
// are dropped and flagged.
// The sample store has two banks, so a new set loads while the previous
// one is being selected. Selection is a 32-pass radix search over the
// store's single read port; each pass reads all n samples of the set.
// Reset clears the set count, the overflow flag, the job queue and the bank
// ownership; the store itself is not cleared. When the receiver stalls, the
// result holds, and loading continues until both banks are occupied.
// ============================================================================
`include "set_median_select_macros.svh"

module set_median_select (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [31:0]        sample,
    input  logic               last,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [32:0] median_doubled,
    output logic [6:0]         set_size,
    output logic               overflowed
);
    import smsel_pkg::*;

    logic      q_push, q_pop, q_full, q_empty;
    job_t      q_job, q_head;
    store_wr_t store_wr;
    bank_rel_t bank_rel;

    smsel_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sample   (sample),
        .last     (last),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_job    (q_job),
        .store_wr (store_wr),
        .bank_rel (bank_rel)
    );

    smsel_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_job),
        .pop      (q_pop),
        .head_job (q_head),
        .full     (q_full),
        .empty    (q_empty)
    );

    smsel_exec u_exec (
        .clk            (clk),
        .rst_n          (rst_n),
        .store_wr       (store_wr),
        .q_empty        (q_empty),
        .q_head         (q_head),
        .q_pop          (q_pop),
        .bank_rel       (bank_rel),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .median_doubled (median_doubled),
        .set_size       (set_size),
        .overflowed     (overflowed)
    );

    `SMS_ASSERT_IMP(a_no_push_when_full, q_full, !q_push)
    `SMS_ASSERT_IMP(a_pop_needs_job, q_pop, !q_empty)
    `SMS_ASSERT_IMP(a_release_on_delivery, bank_rel.valid, out_valid && out_ready)
    `SMS_ASSERT_IMP(a_size_in_range, out_valid, (set_size != 7'd0) && (set_size <= 7'(MAX_SET)))

endmodule
